// ===== rtl/pib_pkg.sv =====
// ----------------------------------------------------------------------------
// pib_pkg: palette index builder shared definitions
// Sizes of the palette chain and the token that walks the row of cells.
// ----------------------------------------------------------------------------
package pib_pkg;

  localparam int ENTRIES   = 256;
  localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W     = $clog2(ENTRIES + 1);
  localparam int COLOR_W   = 24;
  localparam int INDEX_W   = 8;
  localparam int USED_W    = 9;

  localparam logic [COLOR_W-1:0] MASK_RESET = 24'hFFFFFF;

  localparam logic KIND_PIXEL   = 1'b0;
  localparam logic KIND_RESTART = 1'b1;

  // Lookup token handed from cell to cell, one cell per cycle.
  typedef struct packed {
    logic               valid;
    logic [COLOR_W-1:0] pixel;
    logic [IDX_W-1:0]   pos;   // index of the cell the token enters
    logic [CNT_W-1:0]   left;  // filled entries from this cell onward
    logic               hit;
    logic               ins;
    logic [IDX_W-1:0]   idx;
  } pib_token_t;

endpackage

// ===== rtl/pib_cell.sv =====
// ----------------------------------------------------------------------------
// pib_cell: one palette entry of the lookup chain
// Holds one color, compares it against the passing token, and claims the
// token for insertion when it is the first unfilled entry.
// ----------------------------------------------------------------------------
module pib_cell (
  input  logic               clk,
  input  logic               rst,
  input  pib_pkg::pib_token_t tok_in,
  output pib_pkg::pib_token_t tok_out
);
  import pib_pkg::*;

  logic [COLOR_W-1:0] entry;
  pib_token_t         tok_next;
  logic               filled;
  logic               take;

  assign filled = (tok_in.left != '0);
  assign take   = tok_in.valid && !filled && !tok_in.hit && !tok_in.ins;

  always_comb begin
    tok_next      = tok_in;
    tok_next.pos  = IDX_W'(tok_in.pos + 1'b1);
    tok_next.left = filled ? CNT_W'(tok_in.left - 1'b1) : '0;
    if (tok_in.valid && filled && !tok_in.hit && (entry == tok_in.pixel)) begin
      tok_next.hit = 1'b1;
      tok_next.idx = tok_in.pos;
    end
    if (take) begin
      tok_next.ins = 1'b1;
      tok_next.idx = tok_in.pos;
    end
  end

  // first unfilled entry stores the missed color
  always_ff @(posedge clk) begin
    if (take) begin
      entry <= tok_in.pixel;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out <= tok_next;
    end
  end

endmodule

// ===== rtl/palette_index_builder_unit.sv =====
// ----------------------------------------------------------------------------
// palette_index_builder_unit: indexed-color palette builder
// A pixel lookup walks a row of ENTRIES cells, one cell per cycle; the
// result strobes when the token leaves the last cell and busy drops with
// it, so a new pixel is taken only after the previous result has strobed.
// A restart beat strobes its result in the cycle after acceptance and
// leaves busy low. Chain length sets the latency. Results cannot be stalled.
// Synchronous reset empties the palette and sets the mask to all ones.
// ----------------------------------------------------------------------------
module palette_index_builder_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          kind,
  input  logic [pib_pkg::COLOR_W-1:0]   pixel_color,
  output logic                          done,
  output logic [pib_pkg::INDEX_W-1:0]   color_index,
  output logic                          was_inserted,
  output logic                          palette_overflow,
  output logic [pib_pkg::USED_W-1:0]    entries_used,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pib_pkg::COLOR_W-1:0]   cfg_data
);
  import pib_pkg::*;

  logic [COLOR_W-1:0] color_mask;
  logic [CNT_W-1:0]   fill_count;
  logic               accept;
  pib_token_t         head;
  pib_token_t         chain [ENTRIES+1];
  pib_token_t         tail;

  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  always_comb begin
    head       = '0;
    head.valid = accept && (kind == KIND_PIXEL);
    head.pixel = pixel_color & color_mask;
    head.left  = fill_count;
  end

  assign chain[0] = head;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    pib_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .tok_in  (chain[i]),
      .tok_out (chain[i+1])
    );
  end

  assign tail = chain[ENTRIES];

  always_ff @(posedge clk) begin
    if (rst) begin
      color_mask <= MASK_RESET;
    end else if (cfg_valid && cfg_ready) begin
      color_mask <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      done       <= 1'b0;
      fill_count <= '0;
    end else begin
      done <= 1'b0;
      if (accept && (kind == KIND_RESTART)) begin
        fill_count       <= '0;
        done             <= 1'b1;
        color_index      <= '0;
        was_inserted     <= 1'b0;
        palette_overflow <= 1'b0;
        entries_used     <= '0;
      end else if (accept) begin
        busy <= 1'b1;
      end
      // token leaves the last cell: post the beat and release
      if (tail.valid) begin
        busy             <= 1'b0;
        done             <= 1'b1;
        fill_count       <= CNT_W'(fill_count + CNT_W'(tail.ins));
        color_index      <= INDEX_W'(tail.idx);
        was_inserted     <= tail.ins;
        palette_overflow <= !tail.hit && !tail.ins;
        entries_used     <= USED_W'(fill_count + CNT_W'(tail.ins));
      end
    end
  end

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result beat while busy");

  a_pixel_sets_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (kind == KIND_PIXEL)) |=> busy)
    else $error("pixel accepted but busy not raised");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= CNT_W'(ENTRIES))
    else $error("fill count beyond palette size");

  a_overflow_clean: assert property (@(posedge clk) disable iff (rst)
    (done && palette_overflow) |-> (!was_inserted && (color_index == '0)
                                    && (entries_used == USED_W'(ENTRIES))))
    else $error("overflow beat malformed");

  a_tail_single: assert property (@(posedge clk) disable iff (rst)
    tail.valid |=> !tail.valid)
    else $error("two tokens in the chain");

endmodule
